// ===== rtl/iaih_pkg.sv =====
`default_nettype none
package iaih_pkg;

  localparam int NUM_BUCKETS = 15;
  localparam int COUNT_W     = 32;
  localparam int SUM_W       = 64;
  localparam int TS_W        = 63;
  localparam int BKT_W       = 4;
  localparam int QDEPTH      = 2;

  localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(NUM_BUCKETS - 1);

  localparam logic [1:0] FUNC_ENTER = 2'd0;
  localparam logic [1:0] FUNC_EXIT  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // upper bounds (exclusive) in ns for buckets 4..13 of the nonuniform table
  localparam logic signed [SUM_W-1:0] NONUNI_LIM [10] = '{
    64'sd3000, 64'sd11000, 64'sd21000, 64'sd71000, 64'sd86000,
    64'sd101000, 64'sd125000, 64'sd201000, 64'sd801000, 64'sd1000001000
  };
  // inclusive upper bounds in ns for the negative buckets 0..3
  localparam logic signed [SUM_W-1:0] NEG_LIM [4] = '{
    -64'sd1001000, -64'sd101000, -64'sd11000, -64'sd1000
  };
  // exclusive upper bounds in ns for buckets 1..13 of the power-of-two table
  localparam logic signed [SUM_W-1:0] POW2_LIM [13] = '{
    64'sd2000, 64'sd3000, 64'sd5000, 64'sd9000, 64'sd17000, 64'sd33000,
    64'sd65000, 64'sd129000, 64'sd257000, 64'sd513000, 64'sd1025000,
    64'sd2049000, 64'sd4097000
  };

  typedef struct packed {
    logic [1:0]              func;
    logic [BKT_W-1:0]        bucket;
    logic signed [SUM_W-1:0] dur;
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0] active_count;
    logic [COUNT_W-1:0] idle_count;
    logic [SUM_W-1:0]   active_sum;
    logic [SUM_W-1:0]   idle_sum;
  } bkt_entry_t;

  // microsecond truncation folded into the ns thresholds
  function automatic logic [BKT_W-1:0] classify(input logic signed [SUM_W-1:0] dur,
                                                input logic sel);
    logic [BKT_W-1:0] b;
    b = LAST_BUCKET;
    if (sel) begin
      for (int i = 12; i >= 0; i--) begin
        if (dur < POW2_LIM[i]) b = BKT_W'(i + 1);
      end
      if (dur < 64'sd1000) b = '0;
    end else begin
      for (int i = 9; i >= 0; i--) begin
        if (dur < NONUNI_LIM[i]) b = BKT_W'(i + 4);
      end
      for (int i = 3; i >= 0; i--) begin
        if (dur <= NEG_LIM[i]) b = BKT_W'(i);
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/iaih_ram.sv =====
`default_nettype none
module iaih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/iaih_front.sv =====
`default_nettype none
module iaih_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        table_select,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_func,
  input  wire logic [iaih_pkg::TS_W-1:0]   in_timestamp_ns,
  input  wire logic [iaih_pkg::BKT_W-1:0]  in_read_bucket,
  output logic                             push_valid,
  output iaih_pkg::op_t                    push_data,
  input  wire logic                        q_full
);

  logic                              s1_valid_r;
  logic [1:0]                        s1_func_r;
  logic signed [iaih_pkg::SUM_W-1:0] s1_dur_r;
  logic [iaih_pkg::BKT_W-1:0]        s1_rb_r;
  logic [iaih_pkg::TS_W-1:0]         last_enter_r;
  logic [iaih_pkg::TS_W-1:0]         last_exit_r;
  logic                              accept;
  logic signed [iaih_pkg::SUM_W-1:0] dur_nxt;
  logic [iaih_pkg::BKT_W-1:0]        rb_nxt;
  logic [iaih_pkg::BKT_W-1:0]        bucket;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (in_func == iaih_pkg::FUNC_EXIT) begin
      dur_nxt = {1'b0, in_timestamp_ns} - {1'b0, last_enter_r};
    end else begin
      dur_nxt = {1'b0, in_timestamp_ns} - {1'b0, last_exit_r};
    end
    rb_nxt = (in_read_bucket > iaih_pkg::LAST_BUCKET) ? iaih_pkg::LAST_BUCKET : in_read_bucket;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      last_enter_r <= '0;
      last_exit_r  <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        if (in_func == iaih_pkg::FUNC_ENTER) last_enter_r <= in_timestamp_ns;
        if (in_func == iaih_pkg::FUNC_EXIT)  last_exit_r  <= in_timestamp_ns;
      end else if (!q_full) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r <= in_func;
      s1_dur_r  <= dur_nxt;
      s1_rb_r   <= rb_nxt;
    end
  end

  always_comb begin
    case (s1_func_r)
      iaih_pkg::FUNC_ENTER, iaih_pkg::FUNC_EXIT: bucket = iaih_pkg::classify(s1_dur_r,
                                                                             table_select);
      iaih_pkg::FUNC_READ: bucket = s1_rb_r;
      default:             bucket = '0;
    endcase
  end

  assign push_valid       = s1_valid_r;
  assign push_data.func   = s1_func_r;
  assign push_data.bucket = bucket;
  assign push_data.dur    = s1_dur_r;

endmodule
`default_nettype wire

// ===== rtl/iaih_queue.sv =====
`default_nettype none
module iaih_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire iaih_pkg::op_t push_data,
  output logic               full,
  input  wire logic          pop,
  output iaih_pkg::op_t      pop_data,
  output logic               empty
);

  localparam int PTR_W = $clog2(iaih_pkg::QDEPTH);

  iaih_pkg::op_t        entries_r [iaih_pkg::QDEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W:0]       cnt_r;
  logic                 push_ok;
  logic                 pop_ok;

  assign full     = (cnt_r == (PTR_W+1)'(iaih_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_ok)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_ok && !pop_ok) cnt_r <= cnt_r + 1'b1;
      else if (pop_ok && !push_ok) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) entries_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ===== rtl/iaih_back.sv =====
`default_nettype none
module iaih_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire iaih_pkg::op_t                q_data,
  input  wire logic                         q_empty,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [iaih_pkg::BKT_W-1:0]        out_bucket,
  output logic [iaih_pkg::COUNT_W-1:0]      out_active_count,
  output logic [iaih_pkg::COUNT_W-1:0]      out_idle_count,
  output logic signed [iaih_pkg::SUM_W-1:0] out_active_sum_ns,
  output logic signed [iaih_pkg::SUM_W-1:0] out_idle_sum_ns
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_UPD  = 1'b1;

  logic                        state_r;
  logic                        state_nxt;
  iaih_pkg::op_t               op_r;
  logic [iaih_pkg::NUM_BUCKETS-1:0] valid_r;
  logic                        out_valid_r;
  iaih_pkg::bkt_entry_t        rd_entry;
  iaih_pkg::bkt_entry_t        cur;
  iaih_pkg::bkt_entry_t        upd;
  logic                        ram_we;

  iaih_ram #(
    .WIDTH($bits(iaih_pkg::bkt_entry_t)),
    .DEPTH(iaih_pkg::NUM_BUCKETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(op_r.bucket),
    .wdata(upd),
    .raddr(q_data.bucket),
    .rdata(rd_entry)
  );

  // output register must be free or draining before a new bucket is fetched
  assign q_pop = (state_r == B_IDLE) && !q_empty && (!out_valid_r || !out_stall);

  always_comb begin
    case (state_r)
      B_IDLE:  state_nxt = q_pop ? B_UPD : B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // buckets not written since reset or clear read as zero
  always_comb begin
    cur = valid_r[op_r.bucket] ? rd_entry : '0;
    upd = cur;
    case (op_r.func)
      iaih_pkg::FUNC_ENTER: begin
        upd.active_count = (cur.active_count == '1) ? cur.active_count
                                                    : cur.active_count + 1'b1;
        upd.active_sum   = cur.active_sum + op_r.dur;
      end
      iaih_pkg::FUNC_EXIT: begin
        upd.idle_count = (cur.idle_count == '1) ? cur.idle_count : cur.idle_count + 1'b1;
        upd.idle_sum   = cur.idle_sum + op_r.dur;
      end
      iaih_pkg::FUNC_CLEAR: upd = '0;
      default:              upd = cur;
    endcase
  end

  assign ram_we = (state_r == B_UPD) &&
                  ((op_r.func == iaih_pkg::FUNC_ENTER) || (op_r.func == iaih_pkg::FUNC_EXIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_UPD) begin
        out_valid_r <= 1'b1;
        if (op_r.func == iaih_pkg::FUNC_CLEAR) valid_r <= '0;
        else if (ram_we) valid_r[op_r.bucket] <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) op_r <= q_data;
    if (state_r == B_UPD) begin
      out_bucket        <= op_r.bucket;
      out_active_count  <= upd.active_count;
      out_idle_count    <= upd.idle_count;
      out_active_sum_ns <= upd.active_sum;
      out_idle_sum_ns   <= upd.idle_sum;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/idle_active_interval_histogram.sv =====
// idle/active interval histogram
// input channel (in_valid/in_stall): one transaction per event. in_func selects
// enter idle, exit idle, read bucket or clear. enter and exit carry
// in_timestamp_ns; read carries in_read_bucket (15 is taken as 14).
// result channel (out_valid/out_stall): exactly one transaction per input
// transaction, in order, with the hit or read bucket's counts and sums after
// the update; a clear returns bucket 0 and all zeros.
// cfg_we/cfg_wdata writes table_select (0 nonuniform, 1 power-of-two); write
// it only while no transaction is in flight.
// after the accepting edge a transaction passes the queue write, the bucket
// fetch and the update before out_valid. the back end takes no new transaction
// until the read-modify-write of its bucket memory is done.
// a 2-entry queue sits between the classifier and the bucket updater; when
// out_stall holds off the output register the queue fills and in_stall rises.
// reset (rst_n low, synchronous) zeroes the timestamps, all buckets and
// table_select; no clearing pass is needed, and a clear transaction passes
// through the back end like any other.
`default_nettype none
module idle_active_interval_histogram (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_func,
  input  wire logic [iaih_pkg::TS_W-1:0]    in_timestamp_ns,
  input  wire logic [iaih_pkg::BKT_W-1:0]   in_read_bucket,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [iaih_pkg::BKT_W-1:0]        out_bucket,
  output logic [iaih_pkg::COUNT_W-1:0]      out_active_count,
  output logic [iaih_pkg::COUNT_W-1:0]      out_idle_count,
  output logic signed [iaih_pkg::SUM_W-1:0] out_active_sum_ns,
  output logic signed [iaih_pkg::SUM_W-1:0] out_idle_sum_ns
);

  logic          table_select_r;
  logic          push_valid;
  iaih_pkg::op_t push_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  iaih_pkg::op_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_select_r <= 1'b0;
    end else if (cfg_we) begin
      table_select_r <= cfg_wdata;
    end
  end

  iaih_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .table_select   (table_select_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_timestamp_ns(in_timestamp_ns),
    .in_read_bucket (in_read_bucket),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  iaih_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty)
  );

  iaih_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket       (out_bucket),
    .out_active_count (out_active_count),
    .out_idle_count   (out_idle_count),
    .out_active_sum_ns(out_active_sum_ns),
    .out_idle_sum_ns  (out_idle_sum_ns)
  );

endmodule
`default_nettype wire

// ===== rtl/iaih_checker.sv =====
`default_nettype none
module iaih_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [1:0]                   in_func,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [iaih_pkg::BKT_W-1:0]   out_bucket,
  input wire logic [iaih_pkg::COUNT_W-1:0] out_active_count,
  input wire logic [iaih_pkg::COUNT_W-1:0] out_idle_count
);

  // nothing is delivered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bucket) &&
      $stable(out_active_count) && $stable(out_idle_count))
    else $error("stalled result dropped or changed");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bucket <= iaih_pkg::LAST_BUCKET)
    else $error("result bucket out of range");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func))
    else $error("stalled input transaction dropped or changed");

endmodule

bind idle_active_interval_histogram iaih_checker u_iaih_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_bucket      (out_bucket),
  .out_active_count(out_active_count),
  .out_idle_count  (out_idle_count)
);
`default_nettype wire

// ===== test/idle_active_interval_histogram_tb.sv =====
`timescale 1ns / 100ps
module idle_active_interval_histogram_tb;

  typedef logic [iaih_pkg::BKT_W-1:0] bkt_t;
  typedef logic [iaih_pkg::TS_W-1:0]  ts_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [iaih_pkg::TS_W-1:0] TS_MAX = '1;
  localparam logic [iaih_pkg::COUNT_W-1:0] COUNT_SAT = '1;
  localparam longint unsigned NONUNI_US [10] = '{
    2, 10, 20, 70, 85, 100, 124, 200, 800, 1000000
  };
  localparam longint unsigned POW2_US [13] = '{
    1, 2, 4, 8, 16, 32, 64, 128, 256, 512, 1024, 2048, 4096
  };
  // thresholds of both tables, in microseconds
  localparam longint BOUNDARY_US [24] = '{
    0, 1, 2, 4, 8, 10, 16, 20, 32, 64, 70, 85, 100, 124, 128, 200,
    256, 512, 800, 1000, 1024, 2048, 4096, 1000000
  };

  typedef struct {
    logic [iaih_pkg::BKT_W-1:0]   bucket;
    logic [iaih_pkg::COUNT_W-1:0] active_count;
    logic [iaih_pkg::COUNT_W-1:0] idle_count;
    logic [iaih_pkg::SUM_W-1:0]   active_sum;
    logic [iaih_pkg::SUM_W-1:0]   idle_sum;
  } bucket_row_t;

  logic                              clk;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic                              cfg_wdata = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [1:0]                        in_func = iaih_pkg::FUNC_READ;
  logic [iaih_pkg::TS_W-1:0]         in_timestamp_ns = '0;
  logic [iaih_pkg::BKT_W-1:0]        in_read_bucket = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [iaih_pkg::BKT_W-1:0]        out_bucket;
  logic [iaih_pkg::COUNT_W-1:0]      out_active_count;
  logic [iaih_pkg::COUNT_W-1:0]      out_idle_count;
  logic signed [iaih_pkg::SUM_W-1:0] out_active_sum_ns;
  logic signed [iaih_pkg::SUM_W-1:0] out_idle_sum_ns;

  // predicted histogram state
  logic [63:0]                  enter_stamp;
  logic [63:0]                  exit_stamp;
  logic [iaih_pkg::COUNT_W-1:0] active_cnt [iaih_pkg::NUM_BUCKETS];
  logic [iaih_pkg::COUNT_W-1:0] idle_cnt [iaih_pkg::NUM_BUCKETS];
  logic [iaih_pkg::SUM_W-1:0]   active_total [iaih_pkg::NUM_BUCKETS];
  logic [iaih_pkg::SUM_W-1:0]   idle_total [iaih_pkg::NUM_BUCKETS];
  logic                         pow2_table;

  bucket_row_t pending_rows [$];
  int errors = 0;
  int burst_left = 0;

  idle_active_interval_histogram DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_timestamp_ns   (in_timestamp_ns),
    .in_read_bucket    (in_read_bucket),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bucket        (out_bucket),
    .out_active_count  (out_active_count),
    .out_idle_count    (out_idle_count),
    .out_active_sum_ns (out_active_sum_ns),
    .out_idle_sum_ns   (out_idle_sum_ns)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bkt_t span_bucket(input logic [63:0] dur, input logic pow2);
    logic neg;
    logic [63:0] mag;
    longint unsigned us;
    neg = dur[63];
    mag = neg ? -dur : dur;
    us = mag / 64'd1000;
    if (pow2) begin
      if (neg || us == 0) return bkt_t'(0);
      for (int i = 0; i < 13; i++) begin
        if (us <= POW2_US[i]) return bkt_t'(i + 1);
      end
      return iaih_pkg::LAST_BUCKET;
    end
    // a negative span under one microsecond truncates to zero
    if (neg && us != 0) begin
      if (us > 1000) return bkt_t'(0);
      if (us > 100) return bkt_t'(1);
      if (us > 10) return bkt_t'(2);
      return bkt_t'(3);
    end
    for (int i = 0; i < 10; i++) begin
      if (us <= NONUNI_US[i]) return bkt_t'(i + 4);
    end
    return iaih_pkg::LAST_BUCKET;
  endfunction

  task automatic clear_histogram();
    for (int i = 0; i < iaih_pkg::NUM_BUCKETS; i++) begin
      active_cnt[i] = '0;
      idle_cnt[i] = '0;
      active_total[i] = '0;
      idle_total[i] = '0;
    end
  endtask

  task automatic histogram_update(input logic [1:0] f, input ts_t ts, input bkt_t rb);
    logic [63:0] dur;
    bkt_t b;
    bucket_row_t row;
    b = '0;
    case (f)
      iaih_pkg::FUNC_ENTER: begin
        enter_stamp = {1'b0, ts};
        dur = enter_stamp - exit_stamp;
        b = span_bucket(dur, pow2_table);
        if (active_cnt[b] != COUNT_SAT) active_cnt[b] = active_cnt[b] + 1'b1;
        active_total[b] = active_total[b] + dur;
      end
      iaih_pkg::FUNC_EXIT: begin
        exit_stamp = {1'b0, ts};
        dur = exit_stamp - enter_stamp;
        b = span_bucket(dur, pow2_table);
        if (idle_cnt[b] != COUNT_SAT) idle_cnt[b] = idle_cnt[b] + 1'b1;
        idle_total[b] = idle_total[b] + dur;
      end
      iaih_pkg::FUNC_READ: begin
        b = (rb > iaih_pkg::LAST_BUCKET) ? iaih_pkg::LAST_BUCKET : rb;
      end
      iaih_pkg::FUNC_CLEAR: begin
        clear_histogram();
      end
    endcase
    row.bucket = b;
    row.active_count = active_cnt[b];
    row.idle_count = idle_cnt[b];
    row.active_sum = active_total[b];
    row.idle_sum = idle_total[b];
    pending_rows.push_back(row);
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high after a transaction so back-to-back sends need no second assignment
  task automatic send_txn(input logic [1:0] f, input ts_t ts, input bkt_t rb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_timestamp_ns <= ts;
    in_read_bucket <= rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    histogram_update(f, ts, rb);
  endtask

  // event placed at a given span from the opposite timestamp
  task automatic send_span(input logic [1:0] f, input longint dur);
    logic [63:0] origin;
    logic [63:0] ts;
    origin = (f == iaih_pkg::FUNC_ENTER) ? exit_stamp : enter_stamp;
    ts = origin + dur;
    if (ts[63]) ts = origin - dur;
    send_txn(f, ts[iaih_pkg::TS_W-1:0], bkt_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_table(input logic sel);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    pow2_table = sel;
  endtask

  function automatic longint rand_span();
    longint base;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      base = BOUNDARY_US[$urandom_range(0, 23)] * 1000;
      case ($urandom_range(0, 3))
        0: base = base - 1;
        1: ;
        2: base = base + 999;
        default: base = base + 1000;
      endcase
      return ($urandom_range(0, 4) == 0) ? -base : base;
    end
    if (r < 85) return longint'($urandom_range(0, 5_000_000));
    if (r < 95) return longint'($urandom_range(0, 2_000_000_000));
    return -longint'($urandom_range(0, 2_000_000));
  endfunction

  task automatic test_nonuniform_table();
    set_table(1'b0);
    // first event after reset measures from a zero exit time
    send_txn(iaih_pkg::FUNC_ENTER, 63'd5_000_000_000, '0);
    send_span(iaih_pkg::FUNC_EXIT, -1_001_000);
    send_span(iaih_pkg::FUNC_ENTER, -101_000);
    send_span(iaih_pkg::FUNC_EXIT, -11_000);
    send_span(iaih_pkg::FUNC_ENTER, -1_000);
    send_span(iaih_pkg::FUNC_EXIT, -999);
    send_span(iaih_pkg::FUNC_ENTER, 1_000_000_999);
    send_span(iaih_pkg::FUNC_EXIT, 1_000_001_000);
    send_txn(iaih_pkg::FUNC_READ, TS_MAX, 4'hf);
    send_txn(iaih_pkg::FUNC_READ, '0, '0);
  endtask

  task automatic test_timestamp_extremes();
    send_txn(iaih_pkg::FUNC_EXIT, TS_MAX, '0);
    send_txn(iaih_pkg::FUNC_ENTER, '0, '1);
    send_txn(iaih_pkg::FUNC_READ, '0, '0);
    send_txn(iaih_pkg::FUNC_CLEAR, TS_MAX, 4'hf);
    send_txn(iaih_pkg::FUNC_READ, '0, iaih_pkg::LAST_BUCKET);
  endtask

  task automatic test_pow2_table();
    set_table(1'b1);
    send_span(iaih_pkg::FUNC_EXIT, 999);
    send_txn(iaih_pkg::FUNC_ENTER, 63'd1_000_000_000, '0);
    send_span(iaih_pkg::FUNC_EXIT, -5_000);
    send_span(iaih_pkg::FUNC_ENTER, 1_999);
    send_span(iaih_pkg::FUNC_EXIT, 4_096_999);
    send_span(iaih_pkg::FUNC_ENTER, 4_097_000);
    send_span(iaih_pkg::FUNC_EXIT, 1_000);
    send_txn(iaih_pkg::FUNC_READ, '0, 4'd13);
    send_txn(iaih_pkg::FUNC_CLEAR, '0, '0);
  endtask

  // mostly alternating enter/exit pairs, with reads, clears and out-of-order events
  task automatic test_random_traffic(input int n_items);
    logic [1:0] next_evt;
    logic [1:0] f;
    int r;
    next_evt = iaih_pkg::FUNC_ENTER;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 76) begin
        f = next_evt;
        if ($urandom_range(0, 9) == 0) begin
          f = (f == iaih_pkg::FUNC_ENTER) ? iaih_pkg::FUNC_EXIT : iaih_pkg::FUNC_ENTER;
        end
        send_span(f, rand_span());
        next_evt = (f == iaih_pkg::FUNC_ENTER) ? iaih_pkg::FUNC_EXIT : iaih_pkg::FUNC_ENTER;
      end else if (r < 84) begin
        f = $urandom_range(0, 1) ? iaih_pkg::FUNC_EXIT : iaih_pkg::FUNC_ENTER;
        send_txn(f, ts_t'({$urandom, $urandom}), bkt_t'($urandom));
        next_evt = (f == iaih_pkg::FUNC_ENTER) ? iaih_pkg::FUNC_EXIT : iaih_pkg::FUNC_ENTER;
      end else if (r < 97) begin
        send_txn(iaih_pkg::FUNC_READ, ts_t'({$urandom, $urandom}),
                 bkt_t'($urandom_range(0, 15)));
      end else begin
        send_txn(iaih_pkg::FUNC_CLEAR, ts_t'({$urandom, $urandom}), bkt_t'($urandom));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bucket_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got bucket %0d",
                 $time, out_bucket);
      end else begin
        want = pending_rows.pop_front();
        check_field("bucket", 64'(want.bucket), 64'(out_bucket));
        check_field("active_count", 64'(want.active_count), 64'(out_active_count));
        check_field("idle_count", 64'(want.idle_count), 64'(out_idle_count));
        check_field("active_sum_ns", want.active_sum, out_active_sum_ns);
        check_field("idle_sum_ns", want.idle_sum, out_idle_sum_ns);
      end
    end
  end

  // receiver back-pressure: short bursts mostly, occasional long holds and free runs
  initial begin
    int hold;
    int r;
    logic level;
    hold = 0;
    level = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          level = 1'b0;
          hold = $urandom_range(0, 7);
        end else if (r < 60) begin
          level = 1'b0;
          hold = $urandom_range(50, 200);
        end else if (r < 88) begin
          level = 1'b1;
          hold = $urandom_range(0, 2);
        end else if (r < 98) begin
          level = 1'b1;
          hold = $urandom_range(3, 11);
        end else begin
          level = 1'b1;
          hold = $urandom_range(30, 80);
        end
      end
      out_stall <= level;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    enter_stamp = '0;
    exit_stamp = '0;
    pow2_table = 1'b0;
    clear_histogram();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_nonuniform_table();
    test_timestamp_extremes();
    test_pow2_table();
    set_table(1'b0);
    test_random_traffic(490);
    set_table(1'b1);
    test_random_traffic(490);
    set_table(1'b0);
    test_random_traffic(490);
    set_table(1'b1);
    test_random_traffic(480);
    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
